// ===== src/glpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpd_pkg
// Shared constants for the grid local peak detector.
// ----------------------------------------------------------------------------
package glpd_pkg;

	localparam int DEF_MAX_COLS    = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	// fixed field widths
	localparam int ROW_W      = 16;
	localparam int CFG_ROWS_W = 16;
	localparam int CFG_COLS_W = 11;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_ROWS = 1'b0;
	localparam logic REG_FRAME_COLS = 1'b1;

	// tuser kind flag
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_DRAIN  = 1'b1;

	localparam logic [CFG_ROWS_W-1:0] FRAME_ROWS_RST = CFG_ROWS_W'(1);
	localparam logic [CFG_COLS_W-1:0] FRAME_COLS_RST = CFG_COLS_W'(1);

endpackage

// ===== src/grid_local_peak_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_peak_detector_core
// Four-neighbor local maximum detector over a row-major raster stream.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_*       in   tuser = func (drain flag), tdata = sample
//  m_*       out  tdata = {peak_col, peak_row}, tlast = frame_end
//  apb       in   frame_rows @ 0x0, frame_cols @ 0x4
//
// One beat per cycle in while s_tready is high; at most one beat out per input
// beat. The limit is the line store: one write and one registered read per
// cycle. A peak for row r-1 leaves on the output register the cycle after the
// beat at (r, c) is taken; s_tready drops only while that register is full
// and m_tready is low. Reset clears counters and output valid, sets config
// to one; the line store is not cleared (row 0 never reads it as a candidate).
// ----------------------------------------------------------------------------
module grid_local_peak_detector_core
	import glpd_pkg::*;
#(
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int COL_W      = $clog2(MAX_COLS),
	localparam int IN_DW      = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_DW     = ((ROW_W + COL_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// stream in
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,  // [SAMPLE_BITS-1:0] sample
	input  logic              s_tuser,  // [0] func
	// stream out
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,  // [15:0] peak_row, then peak_col
	output logic              m_tlast,
	// config
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W  = $clog2(MAX_COLS + 1);
	localparam int EXT_W  = (CNT_W > CFG_COLS_W) ? CNT_W : CFG_COLS_W;
	localparam int WORD_W = 2 * SAMPLE_BITS;

	// ---------------- configuration ----------------
	logic [CFG_ROWS_W-1:0] frame_rows_q;
	logic [CFG_COLS_W-1:0] frame_cols_q;
	logic                  cfg_wr;

	assign pready = 1'b1;
	// paddr[1:0] is ignored; registers are word wide
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= FRAME_ROWS_RST;
			frame_cols_q <= FRAME_COLS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FRAME_ROWS) begin
				frame_rows_q <= pwdata[CFG_ROWS_W-1:0];
			end else begin
				frame_cols_q <= pwdata[CFG_COLS_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_FRAME_ROWS) begin
			prdata = APB_DW'(frame_rows_q);
		end else begin
			prdata = APB_DW'(frame_cols_q);
		end
	end

	// effective frame size: zero acts as one, columns clamp to the store
	logic [CFG_ROWS_W-1:0] rows_eff;
	logic [CNT_W-1:0]      cols_eff;
	logic [EXT_W-1:0]      cols_ext;

	assign rows_eff = (frame_rows_q == '0) ? CFG_ROWS_W'(1) : frame_rows_q;
	assign cols_ext = EXT_W'(frame_cols_q);

	always_comb begin
		if (cols_ext == '0) begin
			cols_eff = CNT_W'(1);
		end else if (cols_ext > EXT_W'(MAX_COLS)) begin
			cols_eff = CNT_W'(MAX_COLS);
		end else begin
			cols_eff = CNT_W'(cols_ext);
		end
	end

	// ---------------- position counters ----------------
	logic             in_beat;
	logic [ROW_W-1:0] row_q;   // rows_eff = drain row
	logic [COL_W-1:0] col_q;
	logic [CNT_W-1:0] col_inc;
	logic             col_last;
	logic [COL_W-1:0] col_nxt;  // column of the next beat
	logic [CNT_W-1:0] nxt_inc;
	logic [COL_W-1:0] col_nxt2; // column after that, wrapped
	logic [COL_W-1:0] col_after; // column after col_q, wrapped (idle read)

	assign in_beat  = s_tvalid & s_tready;
	assign col_inc  = CNT_W'(col_q) + CNT_W'(1);
	assign col_last = (col_inc == cols_eff);
	assign col_nxt  = col_last ? '0 : COL_W'(col_inc);
	assign nxt_inc  = CNT_W'(col_nxt) + CNT_W'(1);
	assign col_nxt2 = (nxt_inc == cols_eff) ? '0 : COL_W'(nxt_inc);
	assign col_after = col_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_beat) begin
			col_q <= col_nxt;
			if (col_last) begin
				row_q <= (row_q == rows_eff) ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	// ---------------- line store and window cells ----------------
	// chain: store read reg (column c+1) -> cur cell (c) -> left cell (c-1)
	logic signed [SAMPLE_BITS-1:0] v;
	logic [WORD_W-1:0]             right_q;
	logic [WORD_W-1:0]             cur_q;
	logic [SAMPLE_BITS-1:0]        left_q;
	logic [WORD_W-1:0]             wword;
	logic [COL_W-1:0]              raddr;
	logic                          wrap_self;

	assign v = ((row_q >= rows_eff) || (s_tuser == FUNC_DRAIN))
		? '0 : $signed(s_tdata[SAMPLE_BITS-1:0]);

	// new column word: {row above <= v, row two above <= old row above}
	assign wword     = {v, cur_q[WORD_W-1:SAMPLE_BITS]};
	assign raddr     = in_beat ? col_nxt2 : col_after;
	assign wrap_self = (col_nxt == col_q); // one-column frame

	glpd_line_store #(
		.DEPTH  (MAX_COLS),
		.WORD_W (WORD_W)
	) u_store (
		.clk     (clk),
		.we      (in_beat),
		.waddr   (col_q),
		.wdata   (wword),
		.raddr   (raddr),
		.rdata_q (right_q)
	);

	glpd_cell #(
		.W (WORD_W)
	) u_cell_cur (
		.clk        (clk),
		.shift      (in_beat),
		.take_fresh (wrap_self),
		.fresh      (wword),
		.chain_in   (right_q),
		.col_q      (cur_q)
	);

	glpd_cell #(
		.W (SAMPLE_BITS)
	) u_cell_left (
		.clk        (clk),
		.shift      (in_beat),
		.take_fresh (1'b0),
		.fresh      (v),
		.chain_in   (cur_q[WORD_W-1:SAMPLE_BITS]),
		.col_q      (left_q)
	);

	// ---------------- peak decision ----------------
	logic signed [SAMPLE_BITS-1:0] cand, up, left, right;
	logic                          is_peak;

	assign cand  = $signed(cur_q[WORD_W-1:SAMPLE_BITS]);
	assign up    = (row_q >= ROW_W'(2)) ? $signed(cur_q[SAMPLE_BITS-1:0]) : '0;
	assign left  = (col_q != '0) ? $signed(left_q) : '0;
	assign right = col_last ? '0 : $signed(right_q[WORD_W-1:SAMPLE_BITS]);

	assign is_peak = (row_q != '0) && (cand >= up) && (cand >= v)
		&& (cand >= left) && (cand >= right);

	// ---------------- output register ----------------
	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_end_q;

	assign s_tready = ~out_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= in_beat & is_peak;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_row_q <= row_q - ROW_W'(1);
			out_col_q <= col_q;
			out_end_q <= (row_q == rows_eff) && col_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DW'({out_col_q, out_row_q});
	assign m_tlast  = out_end_q;

endmodule

// ===== src/glpd_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpd_line_store
// Line memory holding {row above, row two above} per column, one write and
// one registered read per cycle; a read of the address written in the same
// cycle returns the new word.
// ----------------------------------------------------------------------------
module glpd_line_store
	import glpd_pkg::*;
#(
	parameter int DEPTH  = DEF_MAX_COLS,
	parameter int WORD_W = 2 * DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WORD_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WORD_W-1:0]        rdata_q
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== src/glpd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpd_cell
// One column cell of the window chain. On a beat it takes its neighbor's
// column, or the freshly written column when the row wraps onto itself.
// ----------------------------------------------------------------------------
module glpd_cell
	import glpd_pkg::*;
#(
	parameter int W = 2 * DEF_SAMPLE_BITS
) (
	input  logic         clk,
	input  logic         shift,
	input  logic         take_fresh,
	input  logic [W-1:0] fresh,
	input  logic [W-1:0] chain_in,
	output logic [W-1:0] col_q
);

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= take_fresh ? fresh : chain_in;
		end
	end

endmodule
